// ===== rtl/failsafe_descent_controller_core_assert.svh =====
// Assertion macros for the failsafe descent controller.
// No dependencies; included by the files that assert.
`ifndef FAILSAFE_DESCENT_CONTROLLER_CORE_ASSERT_SVH
`define FAILSAFE_DESCENT_CONTROLLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FDC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define FDC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define FDC_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define FDC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/fdc_pkg.sv =====
// Types and constants of the failsafe descent controller.
// No dependencies.
package fdc_pkg;

    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_PAUSE    = 2'd1;
    localparam logic [1:0] FUNC_CONTINUE = 2'd2;

    localparam logic [1:0] NAV_NONE     = 2'd0;
    localparam logic [1:0] NAV_ALT_HOLD = 2'd1;
    localparam logic [1:0] NAV_GPS      = 2'd2;
    localparam logic [1:0] NAV_DESCENT  = 2'd3;

    localparam logic [2:0] REG_TAKEOFF   = 3'd0;
    localparam logic [2:0] REG_STEP_PS   = 3'd1;
    localparam logic [2:0] REG_FALL      = 3'd2;
    localparam logic [2:0] REG_MIN_STEP  = 3'd3;
    localparam logic [2:0] REG_THR_OFF   = 3'd4;
    localparam logic [2:0] REG_MIN_FLY   = 3'd5;
    localparam logic [2:0] REG_PKT_TMO   = 3'd6;
    localparam logic [2:0] REG_ALT_PER   = 3'd7;

    localparam logic [13:0] RED_MAX = 14'd8192;
    localparam logic [13:0] CM_TO_UM = 14'd10000;
    localparam logic [31:0] STEP_TIME_RESET = 32'd983040;

    localparam logic [5:0] STEP_DIV_BITS = 6'd32;
    localparam logic [5:0] RAMP_DIV_BITS = 6'd14;

    typedef struct packed {
        logic        start;
        logic [5:0]  steps;
    } div_ctrl_t;

endpackage

// ===== rtl/fdc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses fdc_pkg for the control struct.
module fdc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  fdc_pkg::div_ctrl_t ctrl,
    input  logic [31:0]       upper,
    input  logic [31:0]       low,
    input  logic [31:0]       divisor,
    output logic              done,
    output logic [31:0]       quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] trial;
    logic        ge;

    // The upper part is always below the divisor, so the remainder fits 32 bits.
    assign trial = {rem_reg, low_reg[31]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctrl.steps;
            rem_next  = upper;
            low_next  = low;
            quo_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
            low_next = {low_reg[30:0], 1'b0};
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/failsafe_descent_controller_core.sv =====
// Top level of the multicopter failsafe descent controller.
// Depends on fdc_pkg, fdc_divider and the assertion macro header.
//
// Usage: one item on the s_ channel is one call: tuser carries func (tick,
// pause, continue) and tdata the sensor, receiver and altitude fields. Each
// accepted item gives exactly one result item on the m_ channel.
// The block takes one item at a time. A pause, continue or a tick that
// needs no throttle ramp passes from acceptance through the decision step
// to the result register. A tick that ramps the throttle runs a shared
// multiplier and a restoring divider: without a step time update it runs
// the ramp multiply and a 14-bit division, skipping the division when the
// reduction clamps; when the step time is recomputed from altitude it first
// runs three multiplier passes and a 32-bit division, then the ramp
// multiply and a 14-bit division.
// The result register holds a finished item while the receiver stalls;
// the block accepts the next item meanwhile and holds its own result until
// the register frees.
// Reset clears the controller state, loads the step time reset value and loads the register defaults.
// Configuration writes on cfg_we / cfg_index / cfg_data take effect at once.
`include "failsafe_descent_controller_core_assert.svh"
module failsafe_descent_controller_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: now_ms[31:0], device_errors[8:0], link_timeout,
    // throttle_now[11:0], altitude_cm[31:0], altitude_valid,
    // packet_age_ms[31:0], nav_mode_in[1:0], zero fill
    input  logic [127:0] s_tdata,
    // s_tuser from bit 0: func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: handled, override_valid, throttle_out[11:0],
    // nav_mode_out[1:0], clear_device_errors, clear_link_errors, zero fill
    output logic [23:0]  m_tdata
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_DECIDE = 11'b00000000010,
        ST_SMUL1  = 11'b00000000100,
        ST_SMUL2  = 11'b00000001000,
        ST_SMUL3  = 11'b00000010000,
        ST_SCHK   = 11'b00000100000,
        ST_SDIV   = 11'b00001000000,
        ST_RMUL   = 11'b00010000000,
        ST_RCHK   = 11'b00100000000,
        ST_RDIV   = 11'b01000000000,
        ST_FIN    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [11:0] takeoff_reg, min_fly_reg, thr_off_reg;
    logic [9:0]  step_ps_reg;
    logic [15:0] fall_reg, pkt_tmo_reg, alt_per_reg;
    logic [31:0] min_step_reg;

    // Controller state.
    logic        locked_reg, locked_next;
    logic [11:0] latched_reg, latched_next;
    logic        started_reg, started_next;
    logic [31:0] start_ms_reg, start_ms_next;
    logic        paused_reg, paused_next;
    logic [31:0] pause_ms_reg, pause_ms_next;
    logic [31:0] paused_tot_reg, paused_tot_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] step_reg, step_next;

    // Captured input item.
    logic [1:0]  func_reg;
    logic [31:0] now_reg;
    logic [8:0]  err_reg;
    logic        link_reg;
    logic [11:0] thr_in_reg;
    logic [31:0] alt_reg;
    logic        altv_reg;
    logic [31:0] age_reg;
    logic [1:0]  nav_in_reg;

    // Result under construction and the working registers.
    logic        handled_reg, handled_next;
    logic        ovr_reg, ovr_next;
    logic [11:0] thr_out_reg, thr_out_next;
    logic [1:0]  nav_reg, nav_next;
    logic        clr_dev_reg, clr_dev_next;
    logic        clr_link_reg, clr_link_next;
    logic [31:0] t_reg, t_next;
    logic [54:0] num_reg, num_next;
    logic [57:0] prod_reg, prod_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg, m_data_next;

    // Shared multiplier operands.
    logic [41:0] mul_a;
    logic [15:0] mul_b;

    fdc_pkg::div_ctrl_t div_ctrl;
    logic [31:0] div_upper, div_low, div_divisor;
    logic        div_done;
    logic [31:0] div_quo;

    logic        in_fire, out_free;
    logic [11:0] dthr;
    logic [27:0] den;
    logic [43:0] ramp_hi;
    logic [31:0] st_eff;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign dthr     = (latched_reg > takeoff_reg) ? 12'(latched_reg - takeoff_reg)
                                                  : latched_reg;
    assign den      = prod_reg[27:0];
    assign ramp_hi  = {prod_reg[41:0], 2'b00};
    assign st_eff   = (step_reg == 32'd0) ? 32'd1 : step_reg;

    // Elapsed time, negative values saturate to zero.
    function automatic logic [31:0] elapsed(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
        logic [33:0] e;
        e = {2'b00, a} - {2'b00, b} - {2'b00, c};
        return e[33] ? 32'd0 : e[31:0];
    endfunction

    // Ramped throttle, cut to off below the minimum flying throttle.
    function automatic logic [11:0] ramp_thr(input logic [11:0] lat, input logic [13:0] red,
                                             input logic [11:0] min_fly,
                                             input logic [11:0] off);
        logic signed [14:0] thr;
        thr = $signed({3'b000, lat}) - $signed({1'b0, red});
        return (thr >= $signed({3'b000, min_fly})) ? thr[11:0] : off;
    endfunction

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SMUL1: begin mul_a = {11'b0, alt_reg[30:0]}; mul_b = {6'b0, step_ps_reg}; end
            ST_SMUL2: begin mul_a = {1'b0, prod_reg[40:0]}; mul_b = {2'b0, fdc_pkg::CM_TO_UM}; end
            ST_SMUL3: begin mul_a = {26'b0, fall_reg}; mul_b = {4'b0, dthr}; end
            ST_RMUL:  begin mul_a = {10'b0, t_reg}; mul_b = {6'b0, step_ps_reg}; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        locked_next     = locked_reg;
        latched_next    = latched_reg;
        started_next    = started_reg;
        start_ms_next   = start_ms_reg;
        paused_next     = paused_reg;
        pause_ms_next   = pause_ms_reg;
        paused_tot_next = paused_tot_reg;
        stamp_next      = stamp_reg;
        step_next       = step_reg;
        handled_next    = handled_reg;
        ovr_next        = ovr_reg;
        thr_out_next    = thr_out_reg;
        nav_next        = nav_reg;
        clr_dev_next    = clr_dev_reg;
        clr_link_next   = clr_link_reg;
        t_next          = t_reg;
        num_next        = num_reg;
        prod_next       = {16'b0, mul_a} * {42'b0, mul_b};
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        div_ctrl        = '{start: 1'b0, steps: fdc_pkg::STEP_DIV_BITS};
        div_upper       = '0;
        div_low         = '0;
        div_divisor     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                logic dev_path, link_path, do_ramp;
                logic [1:0] nav;
                dev_path  = 1'b0;
                link_path = 1'b0;
                do_ramp   = 1'b0;
                nav       = nav_in_reg;
                handled_next  = 1'b0;
                ovr_next      = 1'b0;
                thr_out_next  = '0;
                clr_dev_next  = 1'b0;
                clr_link_next = 1'b0;
                case (func_reg)
                    fdc_pkg::FUNC_PAUSE:
                    begin
                        paused_next   = 1'b1;
                        pause_ms_next = now_reg;
                    end
                    fdc_pkg::FUNC_CONTINUE:
                    begin
                        if (paused_reg)
                        begin
                            paused_next     = 1'b0;
                            paused_tot_next = 32'(paused_tot_reg + (now_reg - pause_ms_reg));
                        end
                    end
                    fdc_pkg::FUNC_TICK:
                    begin
                        // Gyro and accelerometer come first; barometer, compass
                        // and GPS faults only drop the matching hold modes.
                        if (err_reg[0] || err_reg[1])
                        begin
                            dev_path = 1'b1;
                        end
                        else
                        begin
                            if (err_reg[2] && nav == fdc_pkg::NAV_ALT_HOLD)
                                nav = fdc_pkg::NAV_NONE;
                            if ((err_reg[3] || err_reg[4]) && nav == fdc_pkg::NAV_GPS)
                                nav = fdc_pkg::NAV_NONE;
                            if (err_reg[8])
                                dev_path = 1'b1;
                            else if (link_reg)
                                link_path = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (dev_path)
                begin
                    handled_next = 1'b1;
                    if (thr_in_reg == thr_off_reg)
                    begin
                        started_next = 1'b0;
                        clr_dev_next = 1'b1;
                        nav          = fdc_pkg::NAV_NONE;
                        if (locked_reg)
                        begin
                            locked_next   = 1'b0;
                            clr_link_next = 1'b1;
                            latched_next  = '0;
                        end
                    end
                    else
                    begin
                        nav = fdc_pkg::NAV_DESCENT;
                        if (!paused_reg)
                        begin
                            do_ramp = 1'b1;
                            started_next = 1'b1;
                            if (!started_reg)
                                start_ms_next = now_reg;
                            t_next = elapsed(now_reg, started_reg ? start_ms_reg : now_reg,
                                             paused_tot_reg);
                        end
                    end
                end
                if (link_path)
                begin
                    handled_next = 1'b1;
                    if (thr_in_reg == thr_off_reg || age_reg <= {16'b0, pkt_tmo_reg})
                    begin
                        clr_link_next = 1'b1;
                        nav           = fdc_pkg::NAV_NONE;
                        if (locked_reg)
                        begin
                            locked_next  = 1'b0;
                            latched_next = '0;
                        end
                    end
                    else
                    begin
                        nav = fdc_pkg::NAV_DESCENT;
                        if (!paused_reg)
                        begin
                            do_ramp = 1'b1;
                            t_next  = elapsed(age_reg, {16'b0, pkt_tmo_reg}, paused_tot_reg);
                        end
                    end
                end
                nav_next = nav;
                if (do_ramp)
                begin
                    if (!locked_reg)
                    begin
                        locked_next  = 1'b1;
                        latched_next = thr_in_reg;
                    end
                    state_next = ST_RMUL;
                    if (32'(now_reg - stamp_reg) > {16'b0, alt_per_reg})
                    begin
                        stamp_next = now_reg;
                        if (altv_reg)
                        begin
                            // Zero or negative numerator: step time falls to its lower bound.
                            if (alt_reg[31] || alt_reg == 32'd0 || step_ps_reg == 10'd0)
                                step_next = min_step_reg;
                            else
                                state_next = ST_SMUL1;
                        end
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SMUL1:
            begin
                state_next = ST_SMUL2;
            end
            ST_SMUL2:
            begin
                state_next = ST_SMUL3;
            end
            ST_SMUL3:
            begin
                num_next   = prod_reg[54:0];
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                // A quotient of 2^32 or more, or a zero divisor, saturates.
                if (den == 28'd0 || num_reg >= {11'b0, den, 16'b0})
                begin
                    step_next  = 32'hFFFF_FFFF;
                    state_next = ST_RMUL;
                end
                else
                begin
                    div_ctrl    = '{start: 1'b1, steps: fdc_pkg::STEP_DIV_BITS};
                    div_upper   = {9'b0, num_reg[54:32]} << 16 | {16'b0, num_reg[31:16]};
                    div_low     = {num_reg[15:0], 16'b0};
                    div_divisor = {4'b0, den};
                    state_next  = ST_SDIV;
                end
            end
            ST_SDIV:
            begin
                if (div_done)
                begin
                    step_next  = (div_quo < min_step_reg) ? min_step_reg : div_quo;
                    state_next = ST_RMUL;
                end
            end
            ST_RMUL:
            begin
                state_next = ST_RCHK;
            end
            ST_RCHK:
            begin
                ovr_next = 1'b1;
                // A quotient of 2^14 or more is clamped without dividing.
                if (ramp_hi >= {12'b0, st_eff})
                begin
                    thr_out_next = ramp_thr(latched_reg, fdc_pkg::RED_MAX, min_fly_reg,
                                            thr_off_reg);
                    state_next   = ST_FIN;
                end
                else
                begin
                    div_ctrl    = '{start: 1'b1, steps: fdc_pkg::RAMP_DIV_BITS};
                    div_upper   = ramp_hi[31:0];
                    div_low     = '0;
                    div_divisor = st_eff;
                    state_next  = ST_RDIV;
                end
            end
            ST_RDIV:
            begin
                if (div_done)
                begin
                    thr_out_next = ramp_thr(latched_reg,
                                            (div_quo[13:0] > fdc_pkg::RED_MAX)
                                                ? fdc_pkg::RED_MAX : div_quo[13:0],
                                            min_fly_reg, thr_off_reg);
                    state_next   = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, clr_link_reg, clr_dev_reg, nav_reg,
                                    ovr_reg ? thr_out_reg : 12'd0, ovr_reg, handled_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    fdc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .upper    (div_upper),
        .low      (div_low),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            takeoff_reg    <= 12'd1300;
            step_ps_reg    <= 10'd25;
            fall_reg       <= 16'd833;
            min_step_reg   <= 32'd65536;
            thr_off_reg    <= 12'd1000;
            min_fly_reg    <= 12'd1100;
            pkt_tmo_reg    <= 16'd500;
            alt_per_reg    <= 16'd20;
            locked_reg     <= 1'b0;
            latched_reg    <= '0;
            started_reg    <= 1'b0;
            start_ms_reg   <= '0;
            paused_reg     <= 1'b0;
            pause_ms_reg   <= '0;
            paused_tot_reg <= '0;
            stamp_reg      <= '0;
            step_reg       <= fdc_pkg::STEP_TIME_RESET;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            locked_reg     <= locked_next;
            latched_reg    <= latched_next;
            started_reg    <= started_next;
            start_ms_reg   <= start_ms_next;
            paused_reg     <= paused_next;
            pause_ms_reg   <= pause_ms_next;
            paused_tot_reg <= paused_tot_next;
            stamp_reg      <= stamp_next;
            step_reg       <= step_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fdc_pkg::REG_TAKEOFF:  takeoff_reg  <= cfg_data[11:0];
                    fdc_pkg::REG_STEP_PS:  step_ps_reg  <= cfg_data[9:0];
                    fdc_pkg::REG_FALL:     fall_reg     <= cfg_data[15:0];
                    fdc_pkg::REG_MIN_STEP: min_step_reg <= cfg_data;
                    fdc_pkg::REG_THR_OFF:  thr_off_reg  <= cfg_data[11:0];
                    fdc_pkg::REG_MIN_FLY:  min_fly_reg  <= cfg_data[11:0];
                    fdc_pkg::REG_PKT_TMO:  pkt_tmo_reg  <= cfg_data[15:0];
                    fdc_pkg::REG_ALT_PER:  alt_per_reg  <= cfg_data[15:0];
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg   <= s_tuser;
            now_reg    <= s_tdata[31:0];
            err_reg    <= s_tdata[40:32];
            link_reg   <= s_tdata[41];
            thr_in_reg <= s_tdata[53:42];
            alt_reg    <= s_tdata[85:54];
            altv_reg   <= s_tdata[86];
            age_reg    <= s_tdata[118:87];
            nav_in_reg <= s_tdata[120:119];
        end
        handled_reg  <= handled_next;
        ovr_reg      <= ovr_next;
        thr_out_reg  <= thr_out_next;
        nav_reg      <= nav_next;
        clr_dev_reg  <= clr_dev_next;
        clr_link_reg <= clr_link_next;
        t_reg        <= t_next;
        num_reg      <= num_next;
        prod_reg     <= prod_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An unlocked override never keeps a latched throttle.
    `FDC_ASSERT_IMPLY(a_unlocked_clear, clk, rst_n, !locked_reg, latched_reg == 12'd0)
    // A throttle override is only reported on a handled tick.
    `FDC_ASSERT_IMPLY(a_ovr_handled, clk, rst_n, m_valid_reg && m_data_reg[1], m_data_reg[0])
    // The divider only reports completion while the sequencer waits for it.
    `FDC_ASSERT_IMPLY(a_div_wait, clk, rst_n, div_done,
                      state_reg == ST_SDIV || state_reg == ST_RDIV)
    // Every accepted item moves to the decision step.
    `FDC_ASSERT_NEXT(a_accept_decide, clk, rst_n, in_fire, state_reg == ST_DECIDE)

endmodule
